// ===== hw/rtl/grouped_pool_list_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent assertion helpers shared by the allocator RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GROUPED_POOL_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define GROUPED_POOL_LIST_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cond holds at every clock edge out of reset.
`define GPLA_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define GPLA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GPLA_ASSERT_NOW(lbl, cond, msg)
`define GPLA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/gpla_pkg.sv =====
// ----------------------------------------------------------------------------
// Grouped pool list allocator package
// Sizes, link encoding, status codes and the link memory request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gpla_pkg;

	localparam int POOL_SLOTS  = 1024;
	localparam int GROUP_COUNT = 8;

	localparam int IDX_W    = $clog2(POOL_SLOTS);
	localparam int GRP_W    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int LINK_W   = IDX_W + 1;
	localparam int ENTRY_W  = 10;
	localparam int GROUP_W  = 3;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	// A link is a slot index with a null flag on top.
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam link_t LINK_NIL = link_t'(1) << IDX_W;
	localparam idx_t  IDX_LAST = IDX_W'(POOL_SLOTS - 1);

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_PAUSED = 2'd2
	} status_t;

	// One read address for both link arrays, one write port per array.
	typedef struct packed {
		idx_t  rd_addr;
		logic  nxt_we;
		idx_t  nxt_addr;
		link_t nxt_data;
		logic  prv_we;
		idx_t  prv_addr;
		link_t prv_data;
	} link_req_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} result_t;

	function automatic logic is_slot(input link_t v);
		return !v[IDX_W];
	endfunction

	function automatic idx_t link_idx(input link_t v);
		return v[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpla_link_mem.sv =====
// ----------------------------------------------------------------------------
// Link memories
// Next and prev link arrays, one write port each, shared registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gpla_link_mem (
	input  wire logic               clk,
	input  wire gpla_pkg::link_req_t req,
	output gpla_pkg::link_t         rd_next,
	output gpla_pkg::link_t         rd_prev
);

	gpla_pkg::link_t next_mem [gpla_pkg::POOL_SLOTS];
	gpla_pkg::link_t prev_mem [gpla_pkg::POOL_SLOTS];
	gpla_pkg::link_t rd_next_q;
	gpla_pkg::link_t rd_prev_q;

	always_ff @(posedge clk) begin
		if (req.nxt_we) begin
			next_mem[req.nxt_addr] <= req.nxt_data;
		end
		rd_next_q <= next_mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.prv_we) begin
			prev_mem[req.prv_addr] <= req.prv_data;
		end
		rd_prev_q <= prev_mem[req.rd_addr];
	end

	assign rd_next = rd_next_q;
	assign rd_prev = rd_prev_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gpla_seq.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Steps one add or remove through the link memories and the list heads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grouped_pool_list_allocator_core_defines.svh"

module gpla_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            op,
	input  wire logic [gpla_pkg::GROUP_W-1:0]    group,
	input  wire logic [gpla_pkg::ENTRY_W-1:0]    entry,
	input  wire logic                            paused,
	output gpla_pkg::link_req_t                  req,
	input  wire gpla_pkg::link_t                 rd_next,
	input  wire gpla_pkg::link_t                 rd_prev,
	input  wire logic                            out_free,
	output gpla_pkg::result_t                    res
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_W1   = 6'b000100,
		S_W2   = 6'b001000,
		S_W3   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                            state_q;
	state_t                            state_d;
	gpla_pkg::idx_t                    clr_q;
	logic                              op_q;
	logic [gpla_pkg::GRP_W-1:0]        grp_q;
	gpla_pkg::idx_t                    idx_q;
	gpla_pkg::link_t                   old_q;
	gpla_pkg::link_t                   free_head_q;
	gpla_pkg::link_t                   group_head_q [gpla_pkg::GROUP_COUNT];
	logic [gpla_pkg::SLOT_W-1:0]       res_slot_q;
	gpla_pkg::status_t                 res_status_q;

	logic                              accept;
	logic                              ent_ok;
	gpla_pkg::idx_t                    ent_idx;
	logic [gpla_pkg::GRP_W-1:0]        grp_in;
	gpla_pkg::link_t                   clr_next;
	gpla_pkg::link_t                   clr_prev;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign ent_ok   = (32'(entry) < gpla_pkg::POOL_SLOTS);
	assign ent_idx  = gpla_pkg::IDX_W'(entry);
	assign grp_in   = gpla_pkg::GRP_W'(32'(group) % gpla_pkg::GROUP_COUNT);

	assign clr_next = (clr_q == gpla_pkg::IDX_LAST) ? gpla_pkg::LINK_NIL
		: gpla_pkg::link_t'(clr_q) + gpla_pkg::link_t'(1);
	assign clr_prev = (clr_q == '0) ? gpla_pkg::LINK_NIL
		: gpla_pkg::link_t'(clr_q) - gpla_pkg::link_t'(1);

	// Link memory requests and next state.
	always_comb begin
		req          = '0;
		req.rd_addr  = idx_q;
		req.nxt_addr = idx_q;
		req.prv_addr = idx_q;
		req.nxt_data = gpla_pkg::LINK_NIL;
		req.prv_data = gpla_pkg::LINK_NIL;
		state_d      = state_q;
		unique case (state_q)
			S_CLR: begin
				req.nxt_we   = 1'b1;
				req.nxt_addr = clr_q;
				req.nxt_data = clr_next;
				req.prv_we   = 1'b1;
				req.prv_addr = clr_q;
				req.prv_data = clr_prev;
				if (clr_q == gpla_pkg::IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.rd_addr = (op == gpla_pkg::OP_REMOVE) ? ent_idx
					: gpla_pkg::link_idx(free_head_q);
				if (accept) begin
					priority if (op == gpla_pkg::OP_REMOVE) begin
						state_d = ent_ok ? S_W1 : S_OUT;
					end else if (paused || !gpla_pkg::is_slot(free_head_q)) begin
						state_d = S_OUT;
					end else begin
						state_d = S_W1;
					end
				end
			end
			S_W1: begin
				if (op_q == gpla_pkg::OP_ADD) begin
					req.prv_we   = gpla_pkg::is_slot(rd_next);
					req.prv_addr = gpla_pkg::link_idx(rd_next);
					req.nxt_we   = 1'b1;
					req.nxt_data = old_q;
				end else begin
					req.nxt_we   = gpla_pkg::is_slot(rd_prev);
					req.nxt_addr = gpla_pkg::link_idx(rd_prev);
					req.nxt_data = rd_next;
					req.prv_we   = gpla_pkg::is_slot(rd_next);
					req.prv_addr = gpla_pkg::link_idx(rd_next);
					req.prv_data = rd_prev;
				end
				state_d = S_W2;
			end
			S_W2: begin
				if (op_q == gpla_pkg::OP_ADD) begin
					req.prv_we = 1'b1;
				end else begin
					req.prv_we   = gpla_pkg::is_slot(free_head_q);
					req.prv_addr = gpla_pkg::link_idx(free_head_q);
					req.prv_data = gpla_pkg::link_t'(idx_q);
					req.nxt_we   = 1'b1;
					req.nxt_data = free_head_q;
				end
				state_d = S_W3;
			end
			S_W3: begin
				if (op_q == gpla_pkg::OP_ADD) begin
					req.prv_we   = gpla_pkg::is_slot(old_q);
					req.prv_addr = gpla_pkg::link_idx(old_q);
					req.prv_data = gpla_pkg::link_t'(idx_q);
				end else begin
					req.prv_we = 1'b1;
				end
				state_d = out_free ? S_IDLE : S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.valid  = ((state_q == S_W3) || (state_q == S_OUT)) && out_free;
	assign res.slot   = res_slot_q;
	assign res.status = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			free_head_q <= '0;
			for (int g = 0; g < gpla_pkg::GROUP_COUNT; g++) begin
				group_head_q[g] <= gpla_pkg::LINK_NIL;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + gpla_pkg::IDX_W'(1);
			end
			if (state_q == S_W1) begin
				if (op_q == gpla_pkg::OP_ADD) begin
					free_head_q <= rd_next;
				end else if (!gpla_pkg::is_slot(rd_prev)) begin
					group_head_q[grp_q] <= rd_next;
				end
			end
			if (state_q == S_W2 && op_q == gpla_pkg::OP_ADD) begin
				group_head_q[grp_q] <= gpla_pkg::link_t'(idx_q);
			end
			if (state_q == S_W3 && op_q == gpla_pkg::OP_REMOVE) begin
				free_head_q <= gpla_pkg::link_t'(idx_q);
			end
		end
	end

	// Item fields and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			grp_q <= grp_in;
			old_q <= group_head_q[grp_in];
			priority if (op == gpla_pkg::OP_REMOVE) begin
				idx_q        <= ent_idx;
				res_slot_q   <= entry;
				res_status_q <= gpla_pkg::ST_DONE;
			end else if (paused) begin
				res_slot_q   <= '0;
				res_status_q <= gpla_pkg::ST_PAUSED;
			end else if (!gpla_pkg::is_slot(free_head_q)) begin
				res_slot_q   <= '0;
				res_status_q <= gpla_pkg::ST_FULL;
			end else begin
				idx_q        <= gpla_pkg::link_idx(free_head_q);
				res_slot_q   <= gpla_pkg::SLOT_W'(gpla_pkg::link_idx(free_head_q));
				res_status_q <= gpla_pkg::ST_DONE;
			end
		end
	end

	`GPLA_ASSERT_NXT(a_accept_step, accept, state_q == S_W1 || state_q == S_OUT, "bad step after accept")
	`GPLA_ASSERT_NOW(a_res_free, !res.valid || out_free, "result issued into a full output register")
	`GPLA_ASSERT_NXT(a_clr_end, state_q == S_CLR && clr_q == gpla_pkg::IDX_LAST, state_q == S_IDLE, "clearing pass did not end")
	`GPLA_ASSERT_NOW(a_idle_quiet, state_q != S_IDLE || (!req.nxt_we && !req.prv_we), "link write while idle")

endmodule

`default_nettype wire

// ===== hw/rtl/grouped_pool_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Grouped pool list allocator core
// Slot pool on doubly linked free and group lists with add and remove items.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall  op, group, entry, paused
//   out      send       out_valid / out_stall slot, status
//
// An add or remove that touches the lists steps from acceptance through a
// registered link read, then three write steps on the single write port of each
// link array. A paused or full add changes nothing and goes from acceptance
// straight to the output step.
// After reset a clearing pass over every slot rebuilds the free chain under in_stall.
// A stalled result waits in the output register; the sequencer holds the next.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_pool_list_allocator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             op,
	input  wire logic [gpla_pkg::GROUP_W-1:0]     group,
	input  wire logic [gpla_pkg::ENTRY_W-1:0]     entry,
	input  wire logic                             paused,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [gpla_pkg::SLOT_W-1:0]           slot,
	output logic [gpla_pkg::STATUS_W-1:0]         status
);

	gpla_pkg::link_req_t           req;
	gpla_pkg::link_t               rd_next;
	gpla_pkg::link_t               rd_prev;
	gpla_pkg::result_t             res;
	logic                          out_free;
	logic                          out_valid_q;
	logic [gpla_pkg::SLOT_W-1:0]   slot_q;
	gpla_pkg::status_t             status_q;

	// The output register can take a result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer: walks one item through its link reads and writes.
	gpla_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.group    (group),
		.entry    (entry),
		.paused   (paused),
		.req      (req),
		.rd_next  (rd_next),
		.rd_prev  (rd_prev),
		.out_free (out_free),
		.res      (res)
	);

	// Next and prev link storage.
	gpla_link_mem u_link_mem (
		.clk     (clk),
		.req     (req),
		.rd_next (rd_next),
		.rd_prev (rd_prev)
	);

	// Output register: load a finished item, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled; res.valid only fires when the slot is free.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			slot_q   <= res.slot;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ===== sim/grouped_pool_list_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Grouped pool list allocator core testbench
// A directed item table, then about 1800 random add and remove items. Every
// reply is checked against a local copy of the slot lists, or against the reply
// written in the table. The sender pauses in bursts, the receiver stalls, and one
// long output hold-off backs up the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_pool_list_allocator_core_tb;

	import gpla_pkg::*;

	localparam int RAND_ITEMS  = 1780;
	localparam int QUIET_LIMIT = 5000;   // clearing pass plus long hold, several times over
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 20;

	typedef struct packed {
		logic               op;
		logic [GROUP_W-1:0] group;
		logic [ENTRY_W-1:0] entry;
		logic               paused;
	} pool_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} pool_reply_t;

	typedef struct packed {
		pool_req_t   req;
		logic        typed;    // reply written out below, not taken from the lists
		pool_reply_t reply;
	} plan_row_t;

	// Slot handed out by an add, with the group it went to.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [GROUP_W-1:0] group;
	} lent_t;

	// Directed items. Free list order is easy to follow from reset, so the slot
	// of the early adds is written out; every remove echoes its entry.
	localparam plan_row_t DIR_PLAN [21] = '{
		'{'{OP_ADD,    3'd0, 10'd0,    1'b1}, 1'b1, '{10'd0,    ST_PAUSED}},  // paused, empty
		'{'{OP_ADD,    3'd0, 10'd0,    1'b0}, 1'b1, '{10'd0,    ST_DONE}},    // first free slot
		'{'{OP_ADD,    3'd7, 10'd1023, 1'b0}, 1'b1, '{10'd1,    ST_DONE}},
		'{'{OP_ADD,    3'd7, 10'd512,  1'b0}, 1'b1, '{10'd2,    ST_DONE}},
		'{'{OP_ADD,    3'd3, 10'd1023, 1'b1}, 1'b1, '{10'd0,    ST_PAUSED}},  // paused, busy
		'{'{OP_REMOVE, 3'd7, 10'd1,    1'b0}, 1'b1, '{10'd1,    ST_DONE}},    // group tail
		'{'{OP_REMOVE, 3'd7, 10'd2,    1'b1}, 1'b1, '{10'd2,    ST_DONE}},    // head, paused ignored
		'{'{OP_ADD,    3'd5, 10'd0,    1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_ADD,    3'd2, 10'd0,    1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_REMOVE, 3'd0, 10'd1023, 1'b0}, 1'b1, '{10'd1023, ST_DONE}},    // slot still free
		'{'{OP_REMOVE, 3'd0, 10'd0,    1'b0}, 1'b1, '{10'd0,    ST_DONE}},    // sole member
		'{'{OP_ADD,    3'd1, 10'd0,    1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_ADD,    3'd4, 10'd0,    1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_ADD,    3'd6, 10'd0,    1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_ADD,    3'd6, 10'd682,  1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_ADD,    3'd6, 10'd341,  1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_REMOVE, 3'd6, 10'd4,    1'b0}, 1'b1, '{10'd4,    ST_DONE}},    // middle of group
		'{'{OP_REMOVE, 3'd6, 10'd3,    1'b1}, 1'b1, '{10'd3,    ST_DONE}},    // tail of group
		'{'{OP_ADD,    3'd4, 10'd1023, 1'b0}, 1'b0, '{10'd0,    ST_DONE}},
		'{'{OP_REMOVE, 3'd5, 10'd2,    1'b0}, 1'b1, '{10'd2,    ST_DONE}},
		'{'{OP_REMOVE, 3'd6, 10'd5,    1'b0}, 1'b1, '{10'd5,    ST_DONE}}     // group goes empty
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                op        = OP_ADD;
	logic [GROUP_W-1:0]  group     = '0;
	logic [ENTRY_W-1:0]  entry     = '0;
	logic                paused    = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SLOT_W-1:0]   slot;
	logic [STATUS_W-1:0] status;

	// Local copy of the link memories.
	link_t nxt_mem [POOL_SLOTS];
	link_t prv_mem [POOL_SLOTS];
	link_t grp_head [GROUP_COUNT];
	link_t free_top;

	pool_reply_t owed_replies [$];
	lent_t       held [$];

	int  mismatches   = 0;
	int  replies_seen = 0;
	int  quiet_cycles = 0;
	int  burst_left   = 0;
	int  full_hits    = 0;
	bit  filling      = 1'b1;
	bit  pool_was_full = 1'b0;

	grouped_pool_list_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.group     (group),
		.entry     (entry),
		.paused    (paused),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.slot      (slot),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit names_slot(input link_t v);
		return v != LINK_NIL;
	endfunction

	// Chain every slot on the free list, leave all groups empty.
	function automatic void clear_lists();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			nxt_mem[i] = (i + 1 < POOL_SLOTS) ? link_t'(i + 1) : LINK_NIL;
			prv_mem[i] = (i == 0) ? LINK_NIL : link_t'(i - 1);
		end
		for (int g = 0; g < GROUP_COUNT; g++)
			grp_head[g] = LINK_NIL;
		free_top = '0;
	endfunction

	// Advance the local lists by one item and return the reply it earns.
	function automatic pool_reply_t apply_to_lists(input pool_req_t r);
		pool_reply_t res;
		int          g;
		link_t       id, old, p, n;
		g          = int'(r.group) % GROUP_COUNT;
		res.slot   = '0;
		res.status = ST_DONE;
		if (r.op == OP_ADD) begin
			// Paused wins over a full pool; neither touches the lists.
			if (r.paused)
				res.status = ST_PAUSED;
			else if (!names_slot(free_top))
				res.status = ST_FULL;
			else begin
				id       = free_top;
				free_top = nxt_mem[id];
				if (names_slot(free_top))
					prv_mem[free_top] = LINK_NIL;
				old         = grp_head[g];
				prv_mem[id] = LINK_NIL;
				nxt_mem[id] = old;
				if (names_slot(old))
					prv_mem[old] = id;
				grp_head[g] = id;
				res.slot    = SLOT_W'(id);
			end
		end else begin
			// Unlink blindly through the slot's own links.
			res.slot = SLOT_W'(r.entry);
			if (int'(r.entry) < POOL_SLOTS) begin
				p = prv_mem[r.entry];
				n = nxt_mem[r.entry];
				if (names_slot(p))
					nxt_mem[p] = n;
				else
					grp_head[g] = n;
				if (names_slot(n))
					prv_mem[n] = p;
				if (names_slot(free_top))
					prv_mem[free_top] = link_t'(r.entry);
				prv_mem[r.entry] = LINK_NIL;
				nxt_mem[r.entry] = free_top;
				free_top         = link_t'(r.entry);
			end
		end
		return res;
	endfunction

	// Keep the record of handed-out slots, and swing between filling the pool
	// and draining it.
	function automatic void track_lending(input pool_req_t r, input pool_reply_t res);
		if (r.op == OP_ADD) begin
			if (res.status == ST_DONE)
				held.push_back('{res.slot, r.group});
			else if (res.status == ST_FULL) begin
				pool_was_full = 1'b1;
				full_hits     = full_hits + 1;
				if (filling && full_hits >= 3)
					filling = 1'b0;
			end
		end else begin
			for (int k = held.size() - 1; k >= 0; k--)
				if (held[k].slot == r.entry)
					held.delete(k);
			if (!filling && held.size() < 24) begin
				filling   = 1'b1;
				full_hits = 0;
			end
		end
	endfunction

	// Mostly well-formed traffic: adds, and removes of slots really held in
	// the named group. Stray removes only start once the pool has been full.
	function automatic pool_req_t draw_item();
		pool_req_t r;
		int        roll, pick;
		roll     = $urandom_range(0, 99);
		r.op     = OP_ADD;
		r.group  = GROUP_W'($urandom);
		r.entry  = ENTRY_W'($urandom);
		r.paused = 1'($urandom_range(0, 1));
		if (pool_was_full && roll < 3) begin
			r.op = OP_REMOVE;
			return r;
		end
		if (roll < 9) begin
			r.paused = 1'b1;
			return r;
		end
		if ((filling ? roll >= 96 : roll >= 28) && held.size() != 0) begin
			pick    = $urandom_range(0, held.size() - 1);
			r.op    = OP_REMOVE;
			r.entry = ENTRY_W'(held[pick].slot);
			r.group = held[pick].group;
		end else
			r.paused = 1'b0;
		return r;
	endfunction

	// Offer one item and hold it until taken, then log the reply it owes.
	task automatic push_item(input pool_req_t r, input logic typed, input pool_reply_t fixed);
		pool_reply_t want;
		in_valid <= 1'b1;
		op       <= r.op;
		group    <= r.group;
		entry    <= r.entry;
		paused   <= r.paused;
		do @(posedge clk); while (in_stall);
		want = apply_to_lists(r);
		track_lending(r, want);
		if (typed)
			owed_replies.push_back(fixed);
		else
			owed_replies.push_back(want);
	endtask

	// Close a burst now and then and drop valid for a random gap.
	task automatic pace();
		int gap;
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stimulus: reset, directed table, random items, then drain.
	initial begin
		clear_lists();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIR_PLAN[i]) begin
			push_item(DIR_PLAN[i].req, DIR_PLAN[i].typed, DIR_PLAN[i].reply);
			pace();
		end
		for (int n = 0; n < RAND_ITEMS; n++) begin
			push_item(draw_item(), 1'b0, pool_reply_t'(0));
			pace();
		end
		in_valid <= 1'b0;
		// Wait out every owed reply, then keep watching for strays.
		while (owed_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Receiver: runs of free flow, light and heavy random stall and a periodic
	// pattern; once, hold off long enough for the input side to back up.
	initial begin
		int  run, mode, tick;
		bit  held_off;
		held_off = 1'b0;
		tick     = 0;
		@(posedge clk);
		forever begin
			if (!held_off && replies_seen >= 300) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				for (int h = 0; h < HOLD_CYCLES; h++)
					@(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				run  = $urandom_range(8, 80);
				repeat (run) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 99) < 35);
						2: out_stall <= (tick % 5) < 2;
						default: out_stall <= ($urandom_range(0, 99) < 80);
					endcase
					tick = tick + 1;
					@(posedge clk);
				end
			end
		end
	end

	// Check each reply taken against the oldest owed one.
	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			replies_seen = replies_seen + 1;
			if (owed_replies.size() == 0) begin
				$display("%0t unexpected reply: slot %0d status %0d", $time, slot, status);
				mismatches = mismatches + 1;
			end else begin
				want = owed_replies.pop_front();
				if (slot !== want.slot) begin
					$display("%0t slot mismatch: expected %0d, actual %0d",
						$time, want.slot, slot);
					mismatches = mismatches + 1;
				end
				if (status !== want.status) begin
					$display("%0t status mismatch: expected %0d, actual %0d",
						$time, want.status, status);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else
			quiet_cycles = quiet_cycles + 1;
	end

endmodule

`default_nettype wire
